### src/sltk_pkg.sv
// Package for the sync-locked slot ticker: transfer payload types, command
// and run-state codes, register map and configuration reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sltk_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [1:0] {
      CMD_COUNT = 2'd0,
      CMD_SYNC  = 2'd1,
      CMD_DONE  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      RUN_IDLE   = 2'd0,
      RUN_SYNCED = 2'd1,
      RUN_FREE   = 2'd2
   } run_type;

   typedef enum logic [2:0] {
      REG_TICK_DIVIDER = 3'd0,
      REG_SYNC_PERIOD  = 3'd1,
      REG_TICK_PERIOD  = 3'd2,
      REG_SYNC_GRACE   = 3'd3,
      REG_LATE_LIMIT   = 3'd4
   } reg_index_type;

   localparam logic [7:0]  TickDividerReset = 8'd1;
   localparam logic [15:0] SyncPeriodReset  = 16'd100;
   localparam logic [15:0] TickPeriodReset  = 16'd10;
   localparam logic [7:0]  SyncGraceReset   = 8'd2;
   localparam logic [7:0]  LateLimitReset   = 8'd10;

   typedef struct packed {
      logic [1:0]  command;
      logic [30:0] sync_stamp;
   } req_type;

   typedef struct packed {
      logic        slot_start;
      logic        overrun;
      logic        sync_late;
      logic        chronically_late;
      logic        sync_early;
      logic [1:0]  run_state;
      logic [30:0] stamp_out;
   } rsp_type;

endpackage
`default_nettype wire

### src/sync_locked_slot_ticker_unit.sv
// Top level of the sync-locked slot ticker: input register, state update
// and result register, plus the APB-style register block.
// Depends on sltk_pkg.
//
//   channel | ports                     | direction | accepted when
//   --------+---------------------------+-----------+--------------------------
//   req     | req_valid/ready/data      | in        | req_valid & req_ready
//   rsp     | rsp_valid/ready/data      | out       | rsp_valid & rsp_ready
//   csr     | psel/penable/pwrite/...   | in        | psel & penable & pwrite
//
// Requests pass the input register, then the result register; one event per
// cycle sustained unless rsp_ready stalls. The state update is a single pass
// of compares and increments between the input and result registers.
// Synchronous reset clears the pipeline valids, run state and counters.
// A stalled result holds the result register; the input register still
// takes one more event, after which req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module sync_locked_slot_ticker_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire sltk_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output sltk_pkg::rsp_type                       rsp_data,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sltk_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [sltk_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [sltk_pkg::CsrDataWidth-1:0]       prdata,
   output logic                                    pready
);
   import sltk_pkg::*;

   // configuration
   logic [7:0]  tick_divider_ff;
   logic [15:0] sync_period_ff;
   logic [15:0] tick_period_ff;
   logic [7:0]  sync_grace_ff;
   logic [7:0]  late_limit_ff;
   logic        csr_write;
   reg_index_type csr_index;

   // pipeline
   logic    s1_valid_ff;
   req_type s1_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_free;
   logic    advance;

   // ticker state
   logic [15:0] count_ff, count_in;
   logic [15:0] phase_ff, phase_in;
   logic [7:0]  divide_ff, divide_in;
   run_type     run_ff, run_in;
   logic [7:0]  tally_ff, tally_in;
   logic        pending_ff, pending_in;
   logic        first_ff, first_in;
   logic [30:0] stamp_ff, stamp_in;

   logic        do_tick;
   logic        slot_flag, overrun_flag, late_flag, chronic_flag, early_flag;
   logic [16:0] window;
   logic [7:0]  div_eff;
   cmd_type     cmd;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divider_ff <= TickDividerReset;
         sync_period_ff  <= SyncPeriodReset;
         tick_period_ff  <= TickPeriodReset;
         sync_grace_ff   <= SyncGraceReset;
         late_limit_ff   <= LateLimitReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_TICK_DIVIDER: tick_divider_ff <= pwdata[7:0];
            REG_SYNC_PERIOD:  sync_period_ff  <= pwdata[15:0];
            REG_TICK_PERIOD:  tick_period_ff  <= pwdata[15:0];
            REG_SYNC_GRACE:   sync_grace_ff   <= pwdata[7:0];
            REG_LATE_LIMIT:   late_limit_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TICK_DIVIDER: prdata = {24'd0, tick_divider_ff};
         REG_SYNC_PERIOD:  prdata = {16'd0, sync_period_ff};
         REG_TICK_PERIOD:  prdata = {16'd0, tick_period_ff};
         REG_SYNC_GRACE:   prdata = {24'd0, sync_grace_ff};
         REG_LATE_LIMIT:   prdata = {24'd0, late_limit_ff};
         default:          prdata = '0;
      endcase
   end

   // handshake
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign advance   = s1_valid_ff & out_free;
   assign req_ready = ~s1_valid_ff | out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // next state
   assign window  = {1'b0, sync_period_ff} + {9'd0, sync_grace_ff};
   assign div_eff = (tick_divider_ff == 8'd0) ? 8'd1 : tick_divider_ff;
   assign cmd     = cmd_type'(s1_data_ff.command);

   always_comb begin
      count_in     = count_ff;
      phase_in     = phase_ff;
      divide_in    = divide_ff;
      run_in       = run_ff;
      tally_in     = tally_ff;
      pending_in   = pending_ff;
      first_in     = first_ff;
      stamp_in     = stamp_ff;
      do_tick      = 1'b0;
      slot_flag    = 1'b0;
      overrun_flag = 1'b0;
      late_flag    = 1'b0;
      chronic_flag = 1'b0;
      early_flag   = 1'b0;
      case (cmd)
         CMD_COUNT: begin
            if (count_ff != 16'hFFFF) begin
               count_in = count_ff + 16'd1;
            end
            if (({1'b0, phase_ff} + 17'd1) >= {1'b0, tick_period_ff}) begin
               phase_in = 16'd0;
            end else begin
               phase_in = phase_ff + 16'd1;
            end
            if ((count_in < sync_period_ff) && (phase_in == 16'd0)) begin
               do_tick = 1'b1;
            end else if ({1'b0, count_in} > window) begin
               late_flag = 1'b1;
               run_in    = RUN_FREE;
               count_in  = 16'd0;
               phase_in  = 16'd0;
               if (tally_ff != 8'hFF) begin
                  tally_in = tally_ff + 8'd1;
               end
               chronic_flag = tally_in > late_limit_ff;
               do_tick      = 1'b1;
            end
         end
         CMD_SYNC: begin
            stamp_in = s1_data_ff.sync_stamp;
            if (run_ff == RUN_SYNCED) begin
               // early when count < period - tick_period/2
               early_flag = ({2'd0, count_ff} + {3'd0, tick_period_ff[15:1]})
                            < {2'd0, sync_period_ff};
               do_tick  = 1'b1;
               count_in = 16'd0;
               phase_in = 16'd0;
            end else if (run_ff == RUN_FREE) begin
               if ({1'b0, count_ff} <= window) begin
                  run_in   = RUN_SYNCED;
                  do_tick  = 1'b1;
                  count_in = 16'd0;
                  phase_in = 16'd0;
                  tally_in = 8'd0;
               end
            end
         end
         CMD_DONE: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               first_in   = 1'b1;
            end
         end
         default: ;
      endcase
      if (do_tick) begin
         if (({1'b0, divide_ff} + 9'd1) >= {1'b0, div_eff}) begin
            slot_flag    = 1'b1;
            overrun_flag = pending_ff;
            if (!first_ff) begin
               run_in = RUN_SYNCED;
            end
            pending_in = 1'b1;
            divide_in  = 8'd0;
         end else begin
            divide_in = divide_ff + 8'd1;
         end
      end
   end

   // result
   always_comb begin
      rsp_data_in.slot_start       = slot_flag;
      rsp_data_in.overrun          = overrun_flag;
      rsp_data_in.sync_late        = late_flag;
      rsp_data_in.chronically_late = chronic_flag;
      rsp_data_in.sync_early       = early_flag;
      rsp_data_in.run_state        = run_in;
      rsp_data_in.stamp_out        = stamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 16'd0;
         phase_ff   <= 16'd0;
         divide_ff  <= 8'd0;
         run_ff     <= RUN_IDLE;
         tally_ff   <= 8'd0;
         pending_ff <= 1'b0;
         first_ff   <= 1'b0;
         stamp_ff   <= 31'd0;
      end else if (advance) begin
         count_ff   <= count_in;
         phase_ff   <= phase_in;
         divide_ff  <= divide_in;
         run_ff     <= run_in;
         tally_ff   <= tally_in;
         pending_ff <= pending_in;
         first_ff   <= first_in;
         stamp_ff   <= stamp_in;
      end
   end

   // checks
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not flushed by reset");

   a_overrun_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.overrun) |-> rsp_data_ff.slot_start)
      else $error("overrun without slot start");

   a_chronic_late: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.chronically_late) |-> rsp_data_ff.sync_late)
      else $error("chronic flag without late sync");

   a_late_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && late_flag) |=> (count_ff == 16'd0 && phase_ff == 16'd0))
      else $error("late sync did not clear the count");

   a_result_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data_ff.run_state == run_ff && rsp_data_ff.stamp_out == stamp_ff))
      else $error("result status differs from state");

endmodule
`default_nettype wire
